// ----- hdl/mbx_pkg.sv -----
package mbx_pkg;

	// Default sizing, handed down from the top level
	localparam int ENDPOINT_COUNT_DEF = 8;
	localparam int QUEUE_SLOTS_DEF    = 4;
	localparam int PAYLOAD_BYTES_DEF  = 8;

	// Field widths
	localparam int REQ_W      = 3;
	localparam int EP_W       = 4;
	localparam int SENDER_W   = 16;
	localparam int TYPE_W     = 16;
	localparam int LEN_W      = 4;
	localparam int PAYLOAD_W  = 64;
	localparam int STATUS_W   = 3;
	localparam int NEW_EP_W   = 3;
	localparam int COUNT_W    = 32;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 136;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SEND    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RECEIVE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_QPEND   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QREJ    = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOFREE  = 3'd4;

	// Input beat layout, last field in the lowest bits
	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [LEN_W-1:0]     length;
		logic [TYPE_W-1:0]    msg_type;
		logic [SENDER_W-1:0]  sender;
		logic [EP_W-1:0]      endpoint;
	} in_beat_t;

	// Result fields carried on the output data bus
	typedef struct packed {
		logic [COUNT_W-1:0]   count;
		logic [PAYLOAD_W-1:0] out_payload;
		logic [LEN_W-1:0]     out_length;
		logic [TYPE_W-1:0]    out_type;
		logic [SENDER_W-1:0]  out_sender;
		logic [NEW_EP_W-1:0]  new_endpoint;
	} out_beat_t;

	// Full result held between execution and the output register
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		out_beat_t           beat;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic merge;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fetch;
	} sts_t;

endpackage

// ----- hdl/mbx_ctrl.sv -----
module mbx_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mbx_pkg::sts_t sts,
	output mbx_pkg::cmd_t cmd
);
	import mbx_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_FETCH,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.exec     = (state_q == S_EVAL);
		cmd.merge    = (state_q == S_FETCH);
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	// Sequence one request at a time and hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= sts.fetch ? S_FETCH : S_DONE;
				end
				S_FETCH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A merge only ever follows an execution step
	a_merge_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> $past(cmd.exec))
		else $error("merge without preceding exec");

	// Only one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready after accept");

	// Never overwrite an output beat that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output overwritten");

endmodule

// ----- hdl/mbx_dp.sv -----
module mbx_dp #(
	parameter int ENDPOINT_COUNT = mbx_pkg::ENDPOINT_COUNT_DEF,
	parameter int QUEUE_SLOTS    = mbx_pkg::QUEUE_SLOTS_DEF,
	parameter int PAYLOAD_BYTES  = mbx_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mbx_pkg::IN_DATA_W-1:0] in_data,
	input  logic [mbx_pkg::REQ_W-1:0]     in_req,
	input  mbx_pkg::cmd_t                 cmd,
	output mbx_pkg::sts_t                 sts,
	output mbx_pkg::out_beat_t            out_beat,
	output logic [mbx_pkg::STATUS_W-1:0]  out_status
);
	import mbx_pkg::*;

	localparam int EW    = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
	localparam int PW    = $clog2(2 * QUEUE_SLOTS);
	localparam int SLOTS = ENDPOINT_COUNT * QUEUE_SLOTS;
	localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PAY_W = 8 * PAYLOAD_BYTES;

	typedef struct packed {
		logic [COUNT_W-1:0] rej;
		logic [PW-1:0]      wp;
		logic [PW-1:0]      rp;
	} est_t;

	typedef struct packed {
		logic [SENDER_W-1:0] sender;
		logic [TYPE_W-1:0]   mtype;
		logic [LEN_W-1:0]    len;
		logic [PAY_W-1:0]    pay;
	} slot_t;

	// Storage
	est_t                est_mem [ENDPOINT_COUNT];
	slot_t               slot_mem [SLOTS];
	logic [ENDPOINT_COUNT-1:0] alloc_q;

	// Request and read-data registers
	in_beat_t            req_q;
	logic [REQ_W-1:0]    req_type_q;
	est_t                est_rd_q;
	slot_t               slot_rd_q;
	res_t                res_q;
	res_t                out_q;

	in_beat_t            in_beat;
	logic [EW+EP_W-1:0]  ep_in_wide;
	logic [EW+EP_W-1:0]  ep_wide;
	logic [EW-1:0]       ep_idx;
	logic                ep_valid;

	logic                free_found;
	logic [EW-1:0]       free_idx;
	logic [EW+NEW_EP_W-1:0] free_wide;

	logic [PW:0]         ptr_diff;
	logic [PW-1:0]       pending;
	logic                full;
	logic                empty;
	logic [PW-1:0]       ptr_sel;
	logic [PW-1:0]       slot_off;
	logic [SAW-1:0]      slot_addr;
	logic [PAY_W-1:0]    pay_masked;

	logic                est_we;
	logic [EW-1:0]       est_wa;
	est_t                est_wd;
	logic                slot_we;
	logic                slot_re;
	logic                alloc_set;
	res_t                res_d;

	assign in_beat    = in_beat_t'(in_data);
	assign ep_in_wide = {{EW{1'b0}}, in_beat.endpoint};

	// Decode the endpoint of the held request
	assign ep_wide  = {{EW{1'b0}}, req_q.endpoint};
	assign ep_idx   = ep_wide[EW-1:0];
	assign ep_valid = (ep_wide < (EW+EP_W)'(ENDPOINT_COUNT)) && alloc_q[ep_idx];

	// Find the lowest free endpoint
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = ENDPOINT_COUNT - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				free_found = 1'b1;
				free_idx   = EW'(i);
			end
		end
	end
	assign free_wide = {{NEW_EP_W{1'b0}}, free_idx};

	// Ring occupancy, pointers count modulo twice the ring size
	assign ptr_diff = {1'b0, est_rd_q.wp} - {1'b0, est_rd_q.rp};
	assign pending  = ptr_diff[PW] ? (ptr_diff[PW-1:0] + PW'(2 * QUEUE_SLOTS))
	                               : ptr_diff[PW-1:0];
	assign full     = (pending >= PW'(QUEUE_SLOTS));
	assign empty    = (est_rd_q.rp == est_rd_q.wp);

	// Slot address of the write or read pointer
	assign ptr_sel   = (req_type_q == REQ_SEND) ? est_rd_q.wp : est_rd_q.rp;
	assign slot_off  = (ptr_sel >= PW'(QUEUE_SLOTS)) ? (ptr_sel - PW'(QUEUE_SLOTS)) : ptr_sel;
	assign slot_addr = SAW'(ep_idx) * SAW'(QUEUE_SLOTS) + SAW'(slot_off);

	// Zero payload bytes past the length
	always_comb begin
		for (int b = 0; b < PAYLOAD_BYTES; b++) begin
			pay_masked[8*b +: 8] = (LEN_W'(b) < req_q.length) ? req_q.payload[8*b +: 8] : 8'd0;
		end
	end

	// Execute the held request
	always_comb begin
		est_we    = 1'b0;
		est_wa    = ep_idx;
		est_wd    = est_rd_q;
		slot_we   = 1'b0;
		slot_re   = 1'b0;
		alloc_set = 1'b0;
		res_d     = '0;
		unique case (req_type_q)
			REQ_CREATE: begin
				if (free_found) begin
					alloc_set              = 1'b1;
					est_we                 = 1'b1;
					est_wa                 = free_idx;
					est_wd                 = '0;
					res_d.status           = ST_OK;
					res_d.beat.new_endpoint = free_wide[NEW_EP_W-1:0];
				end else begin
					res_d.status = ST_NOFREE;
				end
			end
			REQ_SEND: begin
				if (!ep_valid || (req_q.length > LEN_W'(PAYLOAD_BYTES))) begin
					res_d.status = ST_INVALID;
				end else if (full) begin
					est_we       = 1'b1;
					est_wd.rej   = est_rd_q.rej + 1'b1;
					res_d.status = ST_FULL;
				end else begin
					slot_we      = 1'b1;
					est_we       = 1'b1;
					est_wd.wp    = (est_rd_q.wp == PW'(2 * QUEUE_SLOTS - 1)) ? '0
					             : est_rd_q.wp + 1'b1;
					res_d.status = ST_OK;
				end
			end
			REQ_RECEIVE: begin
				if (!ep_valid) begin
					res_d.status = ST_INVALID;
				end else if (empty) begin
					res_d.status = ST_EMPTY;
				end else begin
					slot_re      = 1'b1;
					est_we       = 1'b1;
					est_wd.rp    = (est_rd_q.rp == PW'(2 * QUEUE_SLOTS - 1)) ? '0
					             : est_rd_q.rp + 1'b1;
					res_d.status = ST_OK;
				end
			end
			REQ_QPEND: begin
				if (!ep_valid) res_d.status = ST_INVALID;
				else res_d.beat.count = COUNT_W'(pending);
			end
			REQ_QREJ: begin
				if (!ep_valid) res_d.status = ST_INVALID;
				else res_d.beat.count = est_rd_q.rej;
			end
			default: res_d.status = ST_INVALID;
		endcase
	end

	assign sts.fetch = slot_re;

	// Endpoint flags: set on create, never freed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
		end else if (cmd.exec && alloc_set) begin
			alloc_q[free_idx] <= 1'b1;
		end
	end

	// Capture the request and fetch its endpoint state
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= in_beat;
			req_type_q <= in_req;
			est_rd_q   <= est_mem[ep_in_wide[EW-1:0]];
		end
	end

	// Write back endpoint state
	always_ff @(posedge clk) begin
		if (cmd.exec && est_we) begin
			est_mem[est_wa] <= est_wd;
		end
	end

	// Message slots: store on send, read on receive
	always_ff @(posedge clk) begin
		if (cmd.exec && slot_we) begin
			slot_mem[slot_addr] <= '{sender: req_q.sender, mtype: req_q.msg_type,
			                         len: req_q.length, pay: pay_masked};
		end
		if (cmd.exec && slot_re) begin
			slot_rd_q <= slot_mem[slot_addr];
		end
	end

	// Hold the result, merge received message, load the output beat
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
		end else if (cmd.merge) begin
			res_q.beat.out_sender  <= slot_rd_q.sender;
			res_q.beat.out_type    <= slot_rd_q.mtype;
			res_q.beat.out_length  <= slot_rd_q.len;
			res_q.beat.out_payload <= PAYLOAD_W'(slot_rd_q.pay);
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign out_beat   = out_q.beat;
	assign out_status = out_q.status;

	// A request never both stores and fetches a slot
	a_slot_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(slot_we && slot_re))
		else $error("slot write and read together");

	// Endpoints are never released
	a_alloc_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		($past(alloc_q) & ~alloc_q) == '0)
		else $error("endpoint flag cleared");

	// A fetch is only issued for a receive
	a_fetch_receive: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && slot_re) |-> (req_type_q == REQ_RECEIVE))
		else $error("fetch outside receive");

endmodule

// ----- hdl/multi_endpoint_message_mailbox_top.sv -----
// Message mailbox with a fixed set of endpoints, each a ring of message slots.
// Input channel s_axis: one beat is one request. tuser carries the request kind
// (create, send, receive, query pending, query rejected); tdata carries the
// endpoint, sender, type, length and payload of the request.
// Output channel m_axis: exactly one result beat per request, in request order.
// tuser carries the status; tdata carries the created endpoint, the received
// message fields and the query count, zero where they do not apply.
// Timing: a request is taken, its endpoint state read from memory, then
// executed, and its result is loaded into the output register; a successful
// receive adds a step that merges the message read from the slot memory.
// One request is in flight at a time, so the block takes no new request until
// the result of the last one has been loaded into the output register.
// The output register lets a result wait while the next request is taken; if
// the receiver stalls, that next request completes and then waits for the
// output register before the block takes another.
// Reset clears all endpoint allocations and the controller; slot contents and
// endpoint pointers are written before they are first read, so no clearing
// pass is needed and the block accepts requests straight after reset.
module multi_endpoint_message_mailbox_top #(
	parameter int ENDPOINT_COUNT = mbx_pkg::ENDPOINT_COUNT_DEF,
	parameter int QUEUE_SLOTS    = mbx_pkg::QUEUE_SLOTS_DEF,
	parameter int PAYLOAD_BYTES  = mbx_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// endpoint[3:0], sender[19:4], msg_type[35:20], length[39:36], payload[103:40]
	input  logic [mbx_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// req_type[2:0]
	input  logic [mbx_pkg::REQ_W-1:0]      s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// new_endpoint[2:0], out_sender[18:3], out_type[34:19], out_length[38:35],
	// out_payload[102:39], count[134:103], zero fill [135]
	output logic [mbx_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [mbx_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import mbx_pkg::*;

	cmd_t      cmd;
	sts_t      sts;
	out_beat_t out_beat;

	mbx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbx_dp #(
		.ENDPOINT_COUNT (ENDPOINT_COUNT),
		.QUEUE_SLOTS    (QUEUE_SLOTS),
		.PAYLOAD_BYTES  (PAYLOAD_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (s_axis_tdata),
		.in_req     (s_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_beat   (out_beat),
		.out_status (m_axis_tuser)
	);

	// Pad the result fields to whole bytes
	assign m_axis_tdata = {1'b0, out_beat};

endmodule

// ----- dv/tb_multi_endpoint_message_mailbox_top.sv -----
module tb_multi_endpoint_message_mailbox_top;
	import mbx_pkg::*;

	localparam int EPS       = ENDPOINT_COUNT_DEF;
	localparam int SLOTS     = QUEUE_SLOTS_DEF;
	localparam int PBYTES    = PAYLOAD_BYTES_DEF;
	localparam int PTR_MOD   = 2 * SLOTS;
	localparam int MAX_CYCLES = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [REQ_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	// Mailbox shadow state
	bit        ep_alloc [EPS];
	int        rd_ptr [EPS];
	int        wr_ptr [EPS];
	bit [31:0] rejects [EPS];
	bit [15:0] slot_sender [EPS*SLOTS];
	bit [15:0] slot_type [EPS*SLOTS];
	bit [3:0]  slot_len [EPS*SLOTS];
	bit [63:0] slot_data [EPS*SLOTS];

	res_t replies_due [$];
	int   errors = 0;
	int   n_requests = 0;
	int   n_checked = 0;
	int   status_tally [8];
	int   cycles = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   rx_hold_ask = 0;
	int   rx_hold_left = 0;

	multi_endpoint_message_mailbox_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int queued_msgs(int ep);
		return (wr_ptr[ep] + PTR_MOD - rd_ptr[ep]) % PTR_MOD;
	endfunction

	// Work out the reply to one request and advance the shadow state
	function automatic res_t predict_reply(logic [REQ_W-1:0] req, in_beat_t b);
		res_t r;
		int   ep;
		int   s;
		bit   ok;
		bit   found;
		bit [63:0] mask;
		r = '0;
		ep = b.endpoint;
		ok = (ep < EPS) ? ep_alloc[ep] : 1'b0;
		case (req)
			REQ_CREATE: begin
				r.status = ST_NOFREE;
				found = 1'b0;
				for (int i = 0; i < EPS; i++) begin
					if (!found && !ep_alloc[i]) begin
						found = 1'b1;
						ep_alloc[i] = 1'b1;
						rd_ptr[i] = 0;
						wr_ptr[i] = 0;
						rejects[i] = '0;
						r.status = ST_OK;
						r.beat.new_endpoint = i[NEW_EP_W-1:0];
					end
				end
			end
			REQ_SEND: begin
				if (!ok || b.length > PBYTES) begin
					r.status = ST_INVALID;
				end else if (queued_msgs(ep) >= SLOTS) begin
					rejects[ep] = rejects[ep] + 32'd1;
					r.status = ST_FULL;
				end else begin
					s = ep * SLOTS + (wr_ptr[ep] % SLOTS);
					mask = (b.length >= 8) ? '1 : ((64'd1 << (8 * b.length)) - 64'd1);
					slot_sender[s] = b.sender;
					slot_type[s] = b.msg_type;
					slot_len[s] = b.length;
					slot_data[s] = b.payload & mask;
					wr_ptr[ep] = (wr_ptr[ep] + 1) % PTR_MOD;
					r.status = ST_OK;
				end
			end
			REQ_RECEIVE: begin
				if (!ok) begin
					r.status = ST_INVALID;
				end else if (rd_ptr[ep] == wr_ptr[ep]) begin
					r.status = ST_EMPTY;
				end else begin
					s = ep * SLOTS + (rd_ptr[ep] % SLOTS);
					r.beat.out_sender = slot_sender[s];
					r.beat.out_type = slot_type[s];
					r.beat.out_length = slot_len[s];
					r.beat.out_payload = slot_data[s];
					rd_ptr[ep] = (rd_ptr[ep] + 1) % PTR_MOD;
					r.status = ST_OK;
				end
			end
			REQ_QPEND: begin
				if (!ok)
					r.status = ST_INVALID;
				else
					r.beat.count = queued_msgs(ep);
			end
			REQ_QREJ: begin
				if (!ok)
					r.status = ST_INVALID;
				else
					r.beat.count = rejects[ep];
			end
			default: r.status = ST_INVALID;
		endcase
		return r;
	endfunction

	function automatic in_beat_t make_beat(int ep, bit [15:0] snd, bit [15:0] typ, int len,
			bit [63:0] pay);
		in_beat_t b;
		b.endpoint = EP_W'(ep);
		b.sender = snd;
		b.msg_type = typ;
		b.length = LEN_W'(len);
		b.payload = pay;
		return b;
	endfunction

	// Mostly well-formed requests on real endpoints, with some noise
	function automatic void random_request(output logic [REQ_W-1:0] req, output in_beat_t b);
		int pick;
		b.endpoint = EP_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, EPS - 1)
			: $urandom_range(0, 15));
		b.sender = SENDER_W'($urandom);
		b.msg_type = TYPE_W'($urandom);
		b.length = LEN_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, PBYTES)
			: $urandom_range(0, 15));
		b.payload = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 2)
			req = REQ_CREATE;
		else if (pick < 42)
			req = REQ_SEND;
		else if (pick < 77)
			req = REQ_RECEIVE;
		else if (pick < 87)
			req = REQ_QPEND;
		else if (pick < 95)
			req = REQ_QREJ;
		else
			req = REQ_W'($urandom_range(REQ_QREJ + 1, 7));
	endfunction

	// Offer one request beat and log its reply once accepted
	task automatic send_request(logic [REQ_W-1:0] req, in_beat_t b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		replies_due.push_back(predict_reply(req, b));
		n_requests++;
	endtask

	task automatic send_random(int n);
		logic [REQ_W-1:0] req;
		in_beat_t         b;
		for (int i = 0; i < n; i++) begin
			random_request(req, b);
			send_request(req, b);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// Drive the receiver ready, with long hold-offs on request
	always @(posedge clk) begin
		if (rx_hold_ask != 0) begin
			rx_hold_left = rx_hold_ask;
			rx_hold_ask = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (replies_due.size() == 0) begin
				$error("result beat with no request outstanding");
				errors++;
			end else begin
				want = replies_due.pop_front();
				n_checked++;
				status_tally[want.status]++;
				check_field("status", want.status, m_axis_tuser);
				check_field("new_endpoint", want.beat.new_endpoint, m_axis_tdata[2:0]);
				check_field("out_sender", want.beat.out_sender, m_axis_tdata[18:3]);
				check_field("out_type", want.beat.out_type, m_axis_tdata[34:19]);
				check_field("out_length", want.beat.out_length, m_axis_tdata[38:35]);
				check_field("out_payload", want.beat.out_payload, m_axis_tdata[102:39]);
				check_field("count", want.beat.count, m_axis_tdata[134:103]);
				check_field("zero fill", 64'd0, m_axis_tdata[135]);
			end
		end
	end

	// Requests before any endpoint exists, and unknown request kinds
	task automatic test_unallocated_and_unknown();
		send_request(REQ_SEND, make_beat(0, 16'h1234, 16'h5678, 4, 64'hDEAD_BEEF));
		send_request(REQ_RECEIVE, make_beat(0, 0, 0, 0, 0));
		send_request(REQ_QPEND, make_beat(0, 0, 0, 0, 0));
		send_request(REQ_QREJ, make_beat(0, 0, 0, 0, 0));
		for (int t = REQ_QREJ + 1; t < 8; t++)
			send_request(REQ_W'(t), make_beat(1, 16'hFFFF, 16'hFFFF, 15, '1));
	endtask

	// Allocate all but the top two endpoints
	task automatic test_create_endpoints();
		for (int i = 0; i < EPS - 2; i++)
			send_request(REQ_CREATE, make_beat(15, 0, 0, 0, 0));
	endtask

	// Length extremes, bad endpoints, empty and full rings
	task automatic test_message_extremes();
		send_request(REQ_SEND, make_beat(0, 16'hFFFF, 16'hFFFF, 0, '1));
		send_request(REQ_SEND, make_beat(0, 16'h0000, 16'h0000, PBYTES, '1));
		send_request(REQ_SEND, make_beat(0, 16'hAAAA, 16'h5555, PBYTES + 1, '1));
		send_request(REQ_SEND, make_beat(0, 16'hAAAA, 16'h5555, 15, '1));
		send_request(REQ_SEND, make_beat(15, 16'h0001, 16'h0002, 3, '1));
		send_request(REQ_SEND, make_beat(EPS - 1, 16'h0001, 16'h0002, 3, '1));
		repeat (3)
			send_request(REQ_RECEIVE, make_beat(0, 0, 0, 0, 0));
		for (int i = 1; i <= SLOTS + 1; i++)
			send_request(REQ_SEND, make_beat(1, 16'(i), 16'(~i), i, {$urandom, $urandom}));
		send_request(REQ_QPEND, make_beat(1, 0, 0, 0, 0));
		send_request(REQ_QREJ, make_beat(1, 0, 0, 0, 0));
		send_request(REQ_RECEIVE, make_beat(1, 0, 0, 0, 0));
		send_request(REQ_QPEND, make_beat(15, 0, 0, 0, 0));
	endtask

	// Run out of endpoints
	task automatic test_exhaust_endpoints();
		repeat (3)
			send_request(REQ_CREATE, make_beat(0, 0, 0, 0, 0));
	endtask

	// Hold the receiver off while requests keep coming
	task automatic test_receiver_holdoff();
		rx_hold_ask = 300;
		for (int i = 0; i < 12; i++)
			send_request(REQ_SEND, make_beat(2 + (i % 2), 16'(i), 16'(i),
				$urandom_range(0, PBYTES), {$urandom, $urandom}));
		send_random(12);
	endtask

	// Pause the sender until every reply is back, then resume
	task automatic test_sender_pause();
		wait_drained();
		@(posedge clk);
		send_random(10);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unallocated_and_unknown();
		test_create_endpoints();
		test_message_extremes();

		tx_idle_pct = 7;
		rx_idle_pct = 55;
		send_random(470);
		test_exhaust_endpoints();
		test_receiver_holdoff();

		tx_idle_pct = 55;
		rx_idle_pct = 7;
		send_random(470);
		test_sender_pause();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(450);

		wait_drained();
		repeat (16) @(posedge clk);

		$display("Checked %0d replies to %0d requests across three idle patterns", n_checked,
			n_requests);
		$display("Outcomes: ok %0d, invalid %0d, full %0d, empty %0d, no free endpoint %0d",
			status_tally[ST_OK], status_tally[ST_INVALID], status_tally[ST_FULL],
			status_tally[ST_EMPTY], status_tally[ST_NOFREE]);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mbx_pkg.sv
hdl/mbx_ctrl.sv
hdl/mbx_dp.sv
hdl/multi_endpoint_message_mailbox_top.sv
dv/tb_multi_endpoint_message_mailbox_top.sv
